### rtl/assert_macros.svh
// Assertion macros shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define WPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define WPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/wpd_pkg.sv
// ============================================================================
// wpd_pkg
// Types, constants and helpers of the pixel driver.
// ============================================================================
`timescale 1ns / 1ps

package wpd_pkg;

    localparam int MAX_PIXELS_DEF = 256;
    localparam int BYTE_W         = 8;
    localparam int PIXEL_W        = 24;
    localparam int TICK_W         = 15;
    localparam int CNT_W          = 9;
    localparam int ORDER_W        = 6;
    localparam int CMD_W          = 2;
    localparam int SYM_CNT_W      = 5;
    localparam logic [SYM_CNT_W-1:0] SYMS_PER_PIXEL = 5'd24;
    localparam int APB_ADDR_W     = 5;
    localparam int APB_DATA_W     = 32;

    localparam logic [BYTE_W-1:0] BRIGHT_FULL = 8'd255;
    localparam logic [1:0]        POS_NONE    = 2'b11;

    // register map, indexed by paddr[4:2]
    localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
    localparam logic [2:0] REG_ORDER      = 3'd1;
    localparam logic [2:0] REG_COUNT      = 3'd2;
    localparam logic [2:0] REG_ZERO_HIGH  = 3'd3;
    localparam logic [2:0] REG_ZERO_LOW   = 3'd4;
    localparam logic [2:0] REG_ONE_HIGH   = 3'd5;
    localparam logic [2:0] REG_ONE_LOW    = 3'd6;

    localparam logic [BYTE_W-1:0]  RST_BRIGHTNESS = 8'd255;
    localparam logic [ORDER_W-1:0] RST_ORDER      = 6'd18;
    localparam logic [CNT_W-1:0]   RST_COUNT      = 9'd0;
    localparam logic [TICK_W-1:0]  RST_ZERO_HIGH  = 15'd16;
    localparam logic [TICK_W-1:0]  RST_ZERO_LOW   = 15'd34;
    localparam logic [TICK_W-1:0]  RST_ONE_HIGH   = 15'd32;
    localparam logic [TICK_W-1:0]  RST_ONE_LOW    = 15'd18;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_EMIT  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_EMIT_LOAD
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear_start;
    } st_ctrl_t;

    typedef struct packed {
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
    } sym_timing_t;

    // byte 0 sits in the top byte so it leaves the shift register first
    function automatic logic [PIXEL_W-1:0] place_byte(
        input logic [PIXEL_W-1:0] entry,
        input logic [1:0]         pos,
        input logic [BYTE_W-1:0]  v
    );
        logic [PIXEL_W-1:0] e;
        e = entry;
        unique case (pos)
            2'd0:    e[23:16] = v;
            2'd1:    e[15:8]  = v;
            2'd2:    e[7:0]   = v;
            default: e        = entry;
        endcase
        return e;
    endfunction

endpackage

### rtl/wpd_scaler.sv
// ============================================================================
// wpd_scaler
// Bit-serial brightness scaling of red, green and blue, one brightness bit
// per cycle, shift-and-add on three lanes.
// ============================================================================
`timescale 1ns / 1ps

module wpd_scaler (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [wpd_pkg::BYTE_W-1:0] brightness,
    input  logic [wpd_pkg::BYTE_W-1:0] red,
    input  logic [wpd_pkg::BYTE_W-1:0] green,
    input  logic [wpd_pkg::BYTE_W-1:0] blue,
    output logic                       done,
    output logic [wpd_pkg::BYTE_W-1:0] red_scaled,
    output logic [wpd_pkg::BYTE_W-1:0] green_scaled,
    output logic [wpd_pkg::BYTE_W-1:0] blue_scaled
);
    import wpd_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic [BYTE_W-1:0]     bsh_reg, bsh_next;
    logic                  bypass_reg, bypass_next;
    logic [BYTE_W-1:0]     x_reg [3];
    logic [BYTE_W-1:0]     x_next [3];
    logic [2*BYTE_W-1:0]   p_reg [3];
    logic [2*BYTE_W-1:0]   p_next [3];
    logic [BYTE_W:0]       top_sum [3];

    always_comb
    begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        bsh_next    = bsh_reg;
        bypass_next = bypass_reg;
        done_next   = busy_reg && (cnt_reg == 3'd7);
        for (int k = 0; k < 3; k++)
        begin
            x_next[k]  = x_reg[k];
            top_sum[k] = {1'b0, p_reg[k][2*BYTE_W-1:BYTE_W]}
                         + (bsh_reg[0] ? {1'b0, x_reg[k]} : '0);
            p_next[k]  = p_reg[k];
        end
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = 3'd0;
            bsh_next    = brightness;
            bypass_next = (brightness == BRIGHT_FULL);
            x_next[0]   = red;
            x_next[1]   = green;
            x_next[2]   = blue;
            for (int k = 0; k < 3; k++)
            begin
                p_next[k] = '0;
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 3'd1;
            bsh_next = {1'b0, bsh_reg[BYTE_W-1:1]};
            for (int k = 0; k < 3; k++)
            begin
                p_next[k] = {top_sum[k], p_reg[k][BYTE_W-1:1]};
            end
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bsh_reg    <= bsh_next;
        bypass_reg <= bypass_next;
        for (int k = 0; k < 3; k++)
        begin
            x_reg[k] <= x_next[k];
            p_reg[k] <= p_next[k];
        end
    end

    assign done         = done_reg;
    assign red_scaled   = bypass_reg ? x_reg[0] : p_reg[0][2*BYTE_W-1:BYTE_W];
    assign green_scaled = bypass_reg ? x_reg[1] : p_reg[1][2*BYTE_W-1:BYTE_W];
    assign blue_scaled  = bypass_reg ? x_reg[2] : p_reg[2][2*BYTE_W-1:BYTE_W];

endmodule

### rtl/wpd_store.sv
// ============================================================================
// wpd_store
// Pixel memory with registered read and a zeroing sweep, run after reset
// and on a clear request, one entry per cycle.
// ============================================================================
`timescale 1ns / 1ps

module wpd_store #(
    parameter int MAX_PIXELS = wpd_pkg::MAX_PIXELS_DEF,
    parameter int AW         = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wpd_pkg::st_ctrl_t           ctrl,
    input  logic [AW-1:0]               addr,
    input  logic [wpd_pkg::PIXEL_W-1:0] wdata,
    output logic [wpd_pkg::PIXEL_W-1:0] rdata,
    output logic                        clear_busy
);
    import wpd_pkg::*;

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PIXELS - 1);

    logic [PIXEL_W-1:0] mem [MAX_PIXELS];
    logic [PIXEL_W-1:0] rdata_reg;
    logic               clr_busy_reg, clr_busy_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (ctrl.clear_start)
        begin
            clr_busy_next = 1'b1;
            clr_addr_next = '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (ctrl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata      = rdata_reg;
    assign clear_busy = clr_busy_reg;

endmodule

### rtl/wpd_serializer.sv
// ============================================================================
// wpd_serializer
// Shifts one pixel out MSB first as 24 symbols through an output register.
// ============================================================================
`timescale 1ns / 1ps

module wpd_serializer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [wpd_pkg::PIXEL_W-1:0] pixel,
    input  wpd_pkg::sym_timing_t        timing,
    output logic                        busy,
    output logic                        sym_valid,
    input  logic                        sym_stall,
    output logic                        data_bit,
    output logic [wpd_pkg::TICK_W-1:0]  high_ticks,
    output logic [wpd_pkg::TICK_W-1:0]  low_ticks,
    output logic                        last_symbol
);
    import wpd_pkg::*;

    logic [PIXEL_W-1:0]   sh_reg, sh_next;
    logic [SYM_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 vld_reg, vld_next;
    logic                 bit_reg, bit_next;
    logic                 last_reg, last_next;
    logic [TICK_W-1:0]    high_reg, high_next;
    logic [TICK_W-1:0]    low_reg, low_next;
    logic                 move;

    // output slot is free or its transfer completes this cycle
    assign move = (cnt_reg != '0) && (!vld_reg || !sym_stall);

    always_comb
    begin
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        vld_next  = vld_reg;
        bit_next  = bit_reg;
        last_next = last_reg;
        high_next = high_reg;
        low_next  = low_reg;
        if (load)
        begin
            sh_next  = pixel;
            cnt_next = SYMS_PER_PIXEL;
        end
        else if (move)
        begin
            sh_next  = {sh_reg[PIXEL_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
        if (move)
        begin
            vld_next  = 1'b1;
            bit_next  = sh_reg[PIXEL_W-1];
            last_next = (cnt_reg == 5'd1);
            high_next = sh_reg[PIXEL_W-1] ? timing.one_high : timing.zero_high;
            low_next  = sh_reg[PIXEL_W-1] ? timing.one_low : timing.zero_low;
        end
        else if (!sym_stall)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            vld_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        bit_reg  <= bit_next;
        last_reg <= last_next;
        high_reg <= high_next;
        low_reg  <= low_next;
    end

    assign busy        = (cnt_reg != '0);
    assign sym_valid   = vld_reg;
    assign data_bit    = bit_reg;
    assign high_ticks  = high_reg;
    assign low_ticks   = low_reg;
    assign last_symbol = last_reg;

endmodule

### rtl/ws2812_pixel_driver_unit.sv
// ============================================================================
// ws2812_pixel_driver_unit
// Pixel store with brightness scaling, color ordering and bit-symbol output.
// ============================================================================
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  item     | item_valid / item_stall| cmd, pixel_index, red, green, blue
//  symbol   | sym_valid / sym_stall  | data_bit, high_ticks, low_ticks,
//           |                        | last_symbol
//  config   | APB write/read         | paddr, pwdata, prdata
//
//  Write: the serial scaler runs, then a read-modify-write stores the result.
//  Emit: a store read, then 24 symbols at one per cycle from the shift
//  register while the sink does not stall; the next item is taken while symbols drain.
//  Clear and reset: a zeroing sweep of all MAX_PIXELS entries, items stalled.
//  Symbol stalls hold the output register and delay a following emit.
// ============================================================================
`timescale 1ns / 1ps

module ws2812_pixel_driver_unit #(
    parameter int MAX_PIXELS = wpd_pkg::MAX_PIXELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wpd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [wpd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [wpd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [wpd_pkg::CMD_W-1:0]      cmd,
    input  logic [wpd_pkg::BYTE_W-1:0]     pixel_index,
    input  logic [wpd_pkg::BYTE_W-1:0]     red,
    input  logic [wpd_pkg::BYTE_W-1:0]     green,
    input  logic [wpd_pkg::BYTE_W-1:0]     blue,
    output logic                           sym_valid,
    input  logic                           sym_stall,
    output logic                           data_bit,
    output logic [wpd_pkg::TICK_W-1:0]     high_ticks,
    output logic [wpd_pkg::TICK_W-1:0]     low_ticks,
    output logic                           last_symbol
);
    import wpd_pkg::*;

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam logic [12:0] PIX_LIMIT = 13'(MAX_PIXELS);

    // configuration registers
    logic [BYTE_W-1:0]  brightness_reg;
    logic [ORDER_W-1:0] order_reg;
    logic [CNT_W-1:0]   count_reg;
    sym_timing_t        timing_reg;
    logic               cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg       <= RST_BRIGHTNESS;
            order_reg            <= RST_ORDER;
            count_reg            <= RST_COUNT;
            timing_reg.zero_high <= RST_ZERO_HIGH;
            timing_reg.zero_low  <= RST_ZERO_LOW;
            timing_reg.one_high  <= RST_ONE_HIGH;
            timing_reg.one_low   <= RST_ONE_LOW;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_BRIGHTNESS: brightness_reg       <= pwdata[BYTE_W-1:0];
                REG_ORDER:      order_reg            <= pwdata[ORDER_W-1:0];
                REG_COUNT:      count_reg            <= pwdata[CNT_W-1:0];
                REG_ZERO_HIGH:  timing_reg.zero_high <= pwdata[TICK_W-1:0];
                REG_ZERO_LOW:   timing_reg.zero_low  <= pwdata[TICK_W-1:0];
                REG_ONE_HIGH:   timing_reg.one_high  <= pwdata[TICK_W-1:0];
                REG_ONE_LOW:    timing_reg.one_low   <= pwdata[TICK_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_BRIGHTNESS: prdata = APB_DATA_W'(brightness_reg);
            REG_ORDER:      prdata = APB_DATA_W'(order_reg);
            REG_COUNT:      prdata = APB_DATA_W'(count_reg);
            REG_ZERO_HIGH:  prdata = APB_DATA_W'(timing_reg.zero_high);
            REG_ZERO_LOW:   prdata = APB_DATA_W'(timing_reg.zero_low);
            REG_ONE_HIGH:   prdata = APB_DATA_W'(timing_reg.one_high);
            REG_ONE_LOW:    prdata = APB_DATA_W'(timing_reg.one_low);
            default:        prdata = '0;
        endcase
    end

    // item decode
    state_t             state_reg, state_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [AW+7:0]      idx_wide;
    logic               in_use;
    logic               accept;
    logic               clear_busy;
    st_ctrl_t           st_ctrl;
    logic [AW-1:0]      st_addr;
    logic [PIXEL_W-1:0] st_rdata;
    logic [PIXEL_W-1:0] merged;
    logic               scale_start;
    logic               scale_done;
    logic [BYTE_W-1:0]  r_s, g_s, b_s;
    logic               ser_load;
    logic               ser_busy;

    assign idx_wide   = {{AW{1'b0}}, pixel_index};
    assign in_use     = ({1'b0, pixel_index} < count_reg)
                        && ({5'd0, pixel_index} < PIX_LIMIT);
    assign item_stall = (state_reg != ST_IDLE) || clear_busy;
    assign accept     = item_valid && !item_stall;
    assign st_addr    = (state_reg == ST_IDLE) ? idx_wide[AW-1:0] : addr_reg;

    // green first, then red, then blue; later colors win a shared position
    always_comb
    begin
        merged = st_rdata;
        merged = place_byte(merged, order_reg[3:2], g_s);
        merged = place_byte(merged, order_reg[5:4], r_s);
        merged = place_byte(merged, order_reg[1:0], b_s);
    end

    always_comb
    begin
        state_next          = state_reg;
        addr_next           = addr_reg;
        scale_start         = 1'b0;
        ser_load            = 1'b0;
        st_ctrl.rd_en       = 1'b0;
        st_ctrl.wr_en       = 1'b0;
        st_ctrl.clear_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next = idx_wide[AW-1:0];
                    unique case (cmd)
                        CMD_WRITE:
                        begin
                            if (in_use)
                            begin
                                scale_start   = 1'b1;
                                st_ctrl.rd_en = 1'b1;
                                state_next    = ST_SCALE;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            st_ctrl.clear_start = 1'b1;
                        end
                        CMD_EMIT:
                        begin
                            if (in_use)
                            begin
                                st_ctrl.rd_en = 1'b1;
                                state_next    = ST_EMIT_LOAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCALE:
            begin
                if (scale_done)
                begin
                    st_ctrl.wr_en = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT_LOAD:
            begin
                if (!ser_busy)
                begin
                    ser_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
    end

    wpd_scaler u_scaler (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (scale_start),
        .brightness   (brightness_reg),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .done         (scale_done),
        .red_scaled   (r_s),
        .green_scaled (g_s),
        .blue_scaled  (b_s)
    );

    wpd_store #(
        .MAX_PIXELS (MAX_PIXELS),
        .AW         (AW)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (st_ctrl),
        .addr       (st_addr),
        .wdata      (merged),
        .rdata      (st_rdata),
        .clear_busy (clear_busy)
    );

    wpd_serializer u_ser (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (ser_load),
        .pixel       (st_rdata),
        .timing      (timing_reg),
        .busy        (ser_busy),
        .sym_valid   (sym_valid),
        .sym_stall   (sym_stall),
        .data_bit    (data_bit),
        .high_ticks  (high_ticks),
        .low_ticks   (low_ticks),
        .last_symbol (last_symbol)
    );

`include "assert_macros.svh"

    `WPD_ASSERT_IMPL(a_load_idle_ser, ser_load, !ser_busy)
    `WPD_ASSERT_IMPL(a_no_wr_in_clear, st_ctrl.wr_en, !clear_busy)
    `WPD_ASSERT_IMPL(a_done_in_scale, scale_done, state_reg == ST_SCALE)
    `WPD_ASSERT_NEXT(a_load_fills, ser_load, ser_busy)

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: pixel driver testbench
// Drives write, clear, emit and unused-command transfers with random gaps and symbol stalls,
// reprograms the APB registers between phases, and checks every symbol
// against a local model of the pixel store and the bit encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import wpd_pkg::*;

    localparam int ITEM_TARGET   = 380;
    localparam int SETTLE_CYCLES = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic              level;
        logic [TICK_W-1:0] high_t;
        logic [TICK_W-1:0] low_t;
        logic              is_last;
    } symbol_t;

    class pixel_symbol_sb;
        logic [BYTE_W-1:0]  bright;
        logic [ORDER_W-1:0] order;
        logic [CNT_W-1:0]   count;
        logic [TICK_W-1:0]  zero_hi, zero_lo, one_hi, one_lo;
        logic [PIXEL_W-1:0] pixels [MAX_PIXELS_DEF];
        symbol_t            symbols_due [$];
        int                 mismatches;

        function new();
            bright     = RST_BRIGHTNESS;
            order      = RST_ORDER;
            count      = RST_COUNT;
            zero_hi    = RST_ZERO_HIGH;
            zero_lo    = RST_ZERO_LOW;
            one_hi     = RST_ONE_HIGH;
            one_lo     = RST_ONE_LOW;
            mismatches = 0;
            foreach (pixels[i])
                pixels[i] = '0;
        endfunction

        function void set_reg(logic [2:0] addr, logic [APB_DATA_W-1:0] value);
            case (addr)
                REG_BRIGHTNESS: bright  = value[BYTE_W-1:0];
                REG_ORDER:      order   = value[ORDER_W-1:0];
                REG_COUNT:      count   = value[CNT_W-1:0];
                REG_ZERO_HIGH:  zero_hi = value[TICK_W-1:0];
                REG_ZERO_LOW:   zero_lo = value[TICK_W-1:0];
                REG_ONE_HIGH:   one_hi  = value[TICK_W-1:0];
                REG_ONE_LOW:    one_lo  = value[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [BYTE_W-1:0] dim(logic [BYTE_W-1:0] x);
            logic [2*BYTE_W-1:0] prod;
            if (bright == BRIGHT_FULL)
                return x;
            prod = {8'd0, x} * {8'd0, bright};
            return prod[2*BYTE_W-1:BYTE_W];
        endfunction

        // byte 0 is the top byte of an entry; position three is dropped
        function logic [PIXEL_W-1:0] put_byte(logic [PIXEL_W-1:0] e, logic [1:0] pos,
                                              logic [BYTE_W-1:0] v);
            if (pos != POS_NONE)
                e[PIXEL_W - 1 - BYTE_W * int'(pos) -: BYTE_W] = v;
            return e;
        endfunction

        function bit in_use(logic [BYTE_W-1:0] idx);
            return int'(idx) < ((int'(count) > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF
                                                                 : int'(count));
        endfunction

        // returns 1 when the transfer changes state or produces symbols
        function bit take_item(logic [CMD_W-1:0] op, logic [BYTE_W-1:0] idx,
                               logic [BYTE_W-1:0] r, logic [BYTE_W-1:0] g,
                               logic [BYTE_W-1:0] b);
            logic [PIXEL_W-1:0] e;
            symbol_t            s;
            case (op)
                CMD_WRITE: begin
                    if (!in_use(idx))
                        return 0;
                    e = pixels[idx];
                    e = put_byte(e, order[3:2], dim(g));
                    e = put_byte(e, order[5:4], dim(r));
                    e = put_byte(e, order[1:0], dim(b));
                    pixels[idx] = e;
                    return 1;
                end
                CMD_CLEAR: begin
                    foreach (pixels[i])
                        pixels[i] = '0;
                    return 1;
                end
                CMD_EMIT: begin
                    if (!in_use(idx))
                        return 0;
                    e = pixels[idx];
                    for (int k = 0; k < PIXEL_W; k++)
                    begin
                        s.level   = e[PIXEL_W - 1 - k];
                        s.high_t  = s.level ? one_hi : zero_hi;
                        s.low_t   = s.level ? one_lo : zero_lo;
                        s.is_last = (k == PIXEL_W - 1);
                        symbols_due.push_back(s);
                    end
                    return 1;
                end
                default: return 0;
            endcase
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 100)
                $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_symbol(symbol_t got);
            symbol_t want;
            if (symbols_due.size() == 0)
            begin
                report($sformatf("symbol (bit %0d) with nothing pending", got.level));
                return;
            end
            want = symbols_due.pop_front();
            if (got.level !== want.level)
                report($sformatf("data_bit got %0d want %0d", got.level, want.level));
            if (got.high_t !== want.high_t)
                report($sformatf("high_ticks got %0d want %0d", got.high_t, want.high_t));
            if (got.low_t !== want.low_t)
                report($sformatf("low_ticks got %0d want %0d", got.low_t, want.low_t));
            if (got.is_last !== want.is_last)
                report($sformatf("last_symbol got %0d want %0d", got.is_last, want.is_last));
        endtask

        function int pending();
            return symbols_due.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel, penable, pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  item_valid;
    logic                  item_stall;
    logic [CMD_W-1:0]      cmd;
    logic [BYTE_W-1:0]     pixel_index, red, green, blue;
    logic                  sym_valid;
    logic                  sym_stall = 1'b0;
    logic                  data_bit;
    logic [TICK_W-1:0]     high_ticks, low_ticks;
    logic                  last_symbol;

    pixel_symbol_sb sb;
    bit             calm = 1'b0;
    int             stall_left = 0;
    int             sent = 0;
    int             phase_len = 0;

    ws2812_pixel_driver_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .cmd         (cmd),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .sym_valid   (sym_valid),
        .sym_stall   (sym_stall),
        .data_bit    (data_bit),
        .high_ticks  (high_ticks),
        .low_ticks   (low_ticks),
        .last_symbol (last_symbol)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // symbol sink backpressure, raised at random in bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            sym_stall <= 1'b1;
            stall_left--;
        end
        else if (!calm && $urandom_range(0, 4) == 0)
        begin
            sym_stall  <= 1'b1;
            stall_left = $urandom_range(0, 5);
        end
        else
            sym_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : symbol_monitor
        symbol_t got;
        if (rst_n && sym_valid && !sym_stall)
        begin
            got.level   = data_bit;
            got.high_t  = high_ticks;
            got.low_t   = low_ticks;
            got.is_last = last_symbol;
            sb.check_symbol(got);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (sym_valid && !sym_stall) || (psel && penable))
                idle = 0;
            else
                idle++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic send_item(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] idx,
                             input logic [BYTE_W-1:0] r, input logic [BYTE_W-1:0] g,
                             input logic [BYTE_W-1:0] b);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid  <= 1'b1;
        cmd         <= op;
        pixel_index <= idx;
        red         <= r;
        green       <= g;
        blue        <= b;
        do @(posedge clk); while (item_stall);
        void'(sb.take_item(op, idx, r, g, b));
        sent++;
    endtask

    // drain all symbols, then allow for a clear sweep still in flight
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {addr, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(addr, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [BYTE_W-1:0] b, input logic [ORDER_W-1:0] ord,
                             input logic [CNT_W-1:0] cnt,
                             input logic [TICK_W-1:0] zh, input logic [TICK_W-1:0] zl,
                             input logic [TICK_W-1:0] oh, input logic [TICK_W-1:0] ol);
        settle();
        write_reg(REG_BRIGHTNESS, APB_DATA_W'(b));
        write_reg(REG_ORDER, APB_DATA_W'(ord));
        write_reg(REG_COUNT, APB_DATA_W'(cnt));
        write_reg(REG_ZERO_HIGH, APB_DATA_W'(zh));
        write_reg(REG_ZERO_LOW, APB_DATA_W'(zl));
        write_reg(REG_ONE_HIGH, APB_DATA_W'(oh));
        write_reg(REG_ONE_LOW, APB_DATA_W'(ol));
    endtask

    function automatic logic [BYTE_W-1:0] rand_color();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] rand_ticks();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return TICK_W'($urandom_range(0, 32767));
        endcase
    endfunction

    task automatic random_config();
        logic [BYTE_W-1:0] b;
        logic [CNT_W-1:0]  cnt;
        case ($urandom_range(0, 5))
            0:       b = 8'd0;
            1:       b = 8'd1;
            2:       b = 8'd254;
            3, 4:    b = 8'd255;
            default: b = BYTE_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 7))
            0:       cnt = 9'd0;
            1:       cnt = 9'd1;
            2:       cnt = 9'd255;
            3:       cnt = 9'd256;
            4, 5:    cnt = CNT_W'($urandom_range(2, 12));
            default: cnt = CNT_W'($urandom_range(1, 256));
        endcase
        configure(b, ORDER_W'($urandom_range(0, 63)), cnt,
                  rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks());
    endtask

    // small window of indices so that emits mostly hit written pixels
    task automatic random_phase(input int n);
        int limit, span, pick, idx;
        limit = (int'(sb.count) > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : int'(sb.count);
        span  = (limit < 8) ? limit : 8;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (limit == 0)
                idx = $urandom_range(0, 255);
            else if ($urandom_range(0, 1) == 0)
                idx = $urandom_range(0, span - 1);
            else
                idx = $urandom_range(0, limit - 1);
            if (pick >= 94 && limit < MAX_PIXELS_DEF)
                idx = $urandom_range(limit, 255);
            if (pick < 46 || (pick >= 94 && pick[0]))
                send_item(CMD_WRITE, BYTE_W'(idx), rand_color(), rand_color(), rand_color());
            else if (pick < 86 || pick >= 94)
                send_item(CMD_EMIT, BYTE_W'(idx), rand_color(), rand_color(), rand_color());
            else if (pick < 90)
                send_item(CMD_CLEAR, BYTE_W'(idx), rand_color(), rand_color(), rand_color());
            else
                send_item(CMD_UNUSED, BYTE_W'(idx), rand_color(), rand_color(), rand_color());
        end
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        item_valid  = 1'b0;
        cmd         = CMD_WRITE;
        pixel_index = '0;
        red         = '0;
        green       = '0;
        blue        = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset registers: pixel count is zero, so all of these are ignored
        send_item(CMD_WRITE, 8'd0, 8'd255, 8'd255, 8'd255);
        send_item(CMD_EMIT, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(CMD_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255);
        send_item(CMD_EMIT, 8'd255, 8'd0, 8'd0, 8'd0);

        // full store, unscaled, extreme tick counts
        configure(8'd255, RST_ORDER, 9'd256, 15'd0, 15'd32767, 15'd32767, 15'd0);
        send_item(CMD_WRITE, 8'd0, 8'd255, 8'd0, 8'd0);
        send_item(CMD_WRITE, 8'd255, 8'd0, 8'd255, 8'd0);
        send_item(CMD_WRITE, 8'd128, 8'd0, 8'd0, 8'd255);
        send_item(CMD_EMIT, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(CMD_EMIT, 8'd255, 8'd0, 8'd0, 8'd0);
        send_item(CMD_EMIT, 8'd128, 8'd0, 8'd0, 8'd0);
        send_item(CMD_WRITE, 8'd1, 8'hA5, 8'h5A, 8'hC3);
        send_item(CMD_EMIT, 8'd1, 8'd0, 8'd0, 8'd0);
        send_item(CMD_CLEAR, 8'd77, 8'd0, 8'd0, 8'd0);
        send_item(CMD_EMIT, 8'd1, 8'd0, 8'd0, 8'd0);
        send_item(CMD_EMIT, 8'd255, 8'd0, 8'd0, 8'd0);

        // red dropped, green and blue share byte 1 (blue wins)
        configure(8'd128, 6'b11_01_01, 9'd1, 15'd1, 15'd2, 15'd32766, 15'd32765);
        send_item(CMD_WRITE, 8'd0, 8'd200, 8'd100, 8'd50);
        send_item(CMD_EMIT, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(CMD_WRITE, 8'd1, 8'd255, 8'd255, 8'd255);
        send_item(CMD_EMIT, 8'd1, 8'd0, 8'd0, 8'd0);

        // zero brightness, every color on byte 0
        configure(8'd0, 6'b00_00_00, 9'd255, 15'd32767, 15'd32767, 15'd0, 15'd0);
        send_item(CMD_WRITE, 8'd254, 8'd255, 8'd255, 8'd255);
        send_item(CMD_EMIT, 8'd254, 8'd0, 8'd0, 8'd0);
        send_item(CMD_WRITE, 8'd255, 8'd255, 8'd255, 8'd255);
        send_item(CMD_EMIT, 8'd255, 8'd0, 8'd0, 8'd0);

        // near-full brightness, green dropped
        configure(8'd254, 6'b10_11_00, 9'd256, 15'd100, 15'd200, 15'd300, 15'd400);
        send_item(CMD_WRITE, 8'd3, 8'd255, 8'd255, 8'd255);
        send_item(CMD_EMIT, 8'd3, 8'd0, 8'd0, 8'd0);

        while (sent < ITEM_TARGET)
        begin
            random_config();
            calm = (sent >= ITEM_TARGET - 40) || ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(25, 50);
            if (phase_len > ITEM_TARGET - sent)
                phase_len = ITEM_TARGET - sent;
            random_phase(phase_len);
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
